/* rtl/core/tns_pkg.sv */
// Shared types, constants and helpers for the tracker note sequencer.
// Used by tns_ctrl, tns_datapath and tracker_note_sequencer; depends on nothing.
package tns_pkg;

    localparam int NUM_TRACKS      = 16;
    localparam int MELODY_TRACKS   = 8;
    localparam int NOTES_PER_TRACK = 256;
    localparam int POSITION_BITS   = 20;

    localparam int TRK_W     = $clog2(NUM_TRACKS);
    localparam int IDX_W     = $clog2(NOTES_PER_TRACK);
    localparam int CNT_W     = IDX_W + 1;
    localparam int ADDR_W    = TRK_W + IDX_W;
    localparam int STORE_DEPTH = NUM_TRACKS * NOTES_PER_TRACK;
    localparam int MEL_IDX_W = (MELODY_TRACKS > 1) ? $clog2(MELODY_TRACKS) : 1;
    localparam int DIV_CNT_W = $clog2(POSITION_BITS);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [7:0] NO_KEY = 8'hFF;
    localparam logic [7:0] NO_PAN = 8'hFF;
    localparam logic [7:0] NO_VOL = 8'hFF;
    localparam logic [7:0] VOL_DIV = 8'h7F;

    // input operations
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_SEEK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_END_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_POS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DPB     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BPB     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MET_ON  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLO    = 3'd6;

    typedef enum logic [3:0] {
        EV_NOTE_ON  = 4'd0,
        EV_PAN      = 4'd1,
        EV_VOLUME   = 4'd2,
        EV_STOP     = 4'd3,
        EV_STRONG   = 4'd4,
        EV_WEAK     = 4'd5,
        EV_TICK_END = 4'd6,
        EV_LOADED   = 4'd7,
        EV_FULL     = 4'd8,
        EV_SEEKED   = 4'd9
    } ev_kind_t;

    typedef struct packed {
        logic [1:0]               operation;
        logic [3:0]               track;
        logic [POSITION_BITS-1:0] position;
        logic [7:0]               note_key;
        logic [7:0]               note_length;
        logic [7:0]               note_pan;
        logic [7:0]               note_volume;
    } in_item_t;

    typedef struct packed {
        logic [3:0]               event_kind;
        logic [3:0]               event_track;
        logic [7:0]               event_key;
        logic [7:0]               event_value;
        logic [POSITION_BITS-1:0] play_position;
        logic                     last_event;
    } out_event_t;

    typedef struct packed {
        logic [POSITION_BITS-1:0] pos;
        logic [7:0]               key;
        logic [7:0]               len;
        logic [7:0]               pan;
        logic [7:0]               vol;
    } note_t;

    typedef enum logic [4:0] {
        ACT_NOP,
        ACT_CAPTURE,
        ACT_LD_INIT,
        ACT_LD_READ,
        ACT_LD_SHIFT,
        ACT_LD_WRITE,
        ACT_SK_READ,
        ACT_SK_STEP,
        ACT_SK_SET,
        ACT_SK_FINISH,
        ACT_TK_READ,
        ACT_TK_HIT,
        ACT_TK_ON,
        ACT_TK_DEC,
        ACT_TK_STOP,
        ACT_TK_NEXT,
        ACT_MUL,
        ACT_DIV_DB,
        ACT_DIV_D,
        ACT_ADVANCE
    } dp_act_t;

    typedef struct packed {
        dp_act_t  act;
        logic     emit;
        ev_kind_t kind;
        logic     last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic at_zero;
        logic rd_gt;
        logic sk_has;
        logic rd_lt;
        logic trk_last;
        logic tk_has;
        logic rd_eq;
        logic silenced;
        logic key_on;
        logic pan_set;
        logic vol_set;
        logic melody;
        logic skip;
        logic rem_zero;
        logic sounding;
        logic met_on;
        logic div_last;
        logic zero_db;
        logic zero_d;
        logic wrap;
        logic out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_CHECK,
        ST_LD_FULL,
        ST_LD_READ,
        ST_LD_CMP,
        ST_LD_WRITE,
        ST_SK_READ,
        ST_SK_CMP,
        ST_SK_DONE,
        ST_SK_EMIT,
        ST_TK_READ,
        ST_TK_CHK,
        ST_TK_ON,
        ST_TK_PAN,
        ST_TK_VOL,
        ST_TK_LEN,
        ST_TK_NEXT,
        ST_TK_MUL,
        ST_TK_DIV1,
        ST_TK_DIV2,
        ST_TK_MET,
        ST_TK_END
    } state_t;

    // volume * 100 / 127: reciprocal multiply, then one correction step
    function automatic logic [7:0] vol_scale(input logic [7:0] v);
        logic [14:0] n;
        logic [23:0] m;
        logic [7:0]  q;
        logic [14:0] qm;
        logic [14:0] r;
        n  = 15'({v, 6'b0}) + 15'({v, 5'b0}) + 15'({v, 2'b0});
        m  = 24'(n) * 24'd516;
        q  = m[23:16];
        qm = 15'({q, 7'b0}) - 15'(q);
        r  = n - qm;
        if (r >= 15'(VOL_DIV))
        begin
            q = q + 8'd1;
        end
        return q;
    endfunction

endpackage

/* rtl/core/tns_ctrl.sv */
// Sequencing state machine for the tracker note sequencer.
// Depends on tns_pkg; drives tns_datapath through ctrl_cmd_t and reads dp_status_t.
module tns_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_op,
    output logic                  in_stall,
    input  tns_pkg::dp_status_t   status,
    output tns_pkg::ctrl_cmd_t    cmd
);
    import tns_pkg::*;

    state_t state_reg, state_next;
    logic   wrap_reg, wrap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wrap_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wrap_reg  <= wrap_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        wrap_next  = wrap_reg;
        cmd.act    = ACT_NOP;
        cmd.emit   = 1'b0;
        cmd.kind   = EV_TICK_END;
        cmd.last   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act   = ACT_CAPTURE;
                    wrap_next = 1'b0;
                    if (in_op == OP_LOAD)
                    begin
                        state_next = ST_LD_CHECK;
                    end
                    else if (in_op == OP_TICK)
                    begin
                        state_next = ST_TK_READ;
                    end
                    else if (in_op == OP_SEEK)
                    begin
                        state_next = ST_SK_READ;
                    end
                end
            end
            ST_LD_CHECK:
            begin
                if (status.full)
                begin
                    state_next = ST_LD_FULL;
                end
                else
                begin
                    cmd.act    = ACT_LD_INIT;
                    state_next = ST_LD_READ;
                end
            end
            ST_LD_FULL:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = EV_FULL;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LD_READ:
            begin
                if (status.at_zero)
                begin
                    state_next = ST_LD_WRITE;
                end
                else
                begin
                    cmd.act    = ACT_LD_READ;
                    state_next = ST_LD_CMP;
                end
            end
            ST_LD_CMP:
            begin
                if (status.rd_gt)
                begin
                    cmd.act    = ACT_LD_SHIFT;
                    state_next = ST_LD_READ;
                end
                else
                begin
                    state_next = ST_LD_WRITE;
                end
            end
            ST_LD_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.act    = ACT_LD_WRITE;
                    cmd.emit   = 1'b1;
                    cmd.kind   = EV_LOADED;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SK_READ:
            begin
                if (status.sk_has)
                begin
                    cmd.act    = ACT_SK_READ;
                    state_next = ST_SK_CMP;
                end
                else
                begin
                    cmd.act    = ACT_SK_SET;
                    state_next = status.trk_last ? ST_SK_DONE : ST_SK_READ;
                end
            end
            ST_SK_CMP:
            begin
                if (status.rd_lt)
                begin
                    cmd.act    = ACT_SK_STEP;
                    state_next = ST_SK_READ;
                end
                else
                begin
                    cmd.act    = ACT_SK_SET;
                    state_next = status.trk_last ? ST_SK_DONE : ST_SK_READ;
                end
            end
            ST_SK_DONE:
            begin
                cmd.act    = ACT_SK_FINISH;
                state_next = wrap_reg ? ST_IDLE : ST_SK_EMIT;
            end
            ST_SK_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = EV_SEEKED;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TK_READ:
            begin
                if (status.tk_has)
                begin
                    cmd.act    = ACT_TK_READ;
                    state_next = ST_TK_CHK;
                end
                else
                begin
                    state_next = ST_TK_LEN;
                end
            end
            ST_TK_CHK:
            begin
                if (status.rd_eq)
                begin
                    cmd.act    = ACT_TK_HIT;
                    state_next = status.silenced ? ST_TK_LEN : ST_TK_ON;
                end
                else
                begin
                    state_next = ST_TK_LEN;
                end
            end
            ST_TK_ON:
            begin
                if (!status.key_on)
                begin
                    state_next = ST_TK_PAN;
                end
                else if (status.out_free)
                begin
                    cmd.act    = ACT_TK_ON;
                    cmd.emit   = 1'b1;
                    cmd.kind   = EV_NOTE_ON;
                    state_next = ST_TK_PAN;
                end
            end
            ST_TK_PAN:
            begin
                if (!status.pan_set)
                begin
                    state_next = ST_TK_VOL;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = EV_PAN;
                    state_next = ST_TK_VOL;
                end
            end
            ST_TK_VOL:
            begin
                if (!status.vol_set)
                begin
                    state_next = ST_TK_LEN;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = EV_VOLUME;
                    state_next = ST_TK_LEN;
                end
            end
            ST_TK_LEN:
            begin
                if (!status.melody || status.skip)
                begin
                    state_next = ST_TK_NEXT;
                end
                else if (!status.rem_zero)
                begin
                    cmd.act    = ACT_TK_DEC;
                    state_next = ST_TK_NEXT;
                end
                else if (!status.sounding)
                begin
                    state_next = ST_TK_NEXT;
                end
                else if (status.out_free)
                begin
                    cmd.act    = ACT_TK_STOP;
                    cmd.emit   = 1'b1;
                    cmd.kind   = EV_STOP;
                    state_next = ST_TK_NEXT;
                end
            end
            ST_TK_NEXT:
            begin
                cmd.act    = ACT_TK_NEXT;
                state_next = status.trk_last ? ST_TK_MUL : ST_TK_READ;
            end
            ST_TK_MUL:
            begin
                if (status.met_on)
                begin
                    cmd.act    = ACT_MUL;
                    state_next = ST_TK_DIV1;
                end
                else
                begin
                    state_next = ST_TK_END;
                end
            end
            ST_TK_DIV1:
            begin
                cmd.act = ACT_DIV_DB;
                if (status.div_last)
                begin
                    state_next = ST_TK_DIV2;
                end
            end
            ST_TK_DIV2:
            begin
                cmd.act = ACT_DIV_D;
                if (status.div_last)
                begin
                    state_next = ST_TK_MET;
                end
            end
            ST_TK_MET:
            begin
                if (!status.zero_db && !status.zero_d)
                begin
                    state_next = ST_TK_END;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = status.zero_db ? EV_STRONG : EV_WEAK;
                    state_next = ST_TK_END;
                end
            end
            ST_TK_END:
            begin
                if (status.out_free)
                begin
                    cmd.act  = ACT_ADVANCE;
                    cmd.emit = 1'b1;
                    cmd.kind = EV_TICK_END;
                    cmd.last = 1'b1;
                    if (status.wrap)
                    begin
                        wrap_next  = 1'b1;
                        state_next = ST_SK_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/tns_datapath.sv */
// Note store, per-track pointers, configuration, metronome divider and output register.
// Depends on tns_pkg; commanded by tns_ctrl.
module tns_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tns_pkg::in_item_t                 in_data,
    input  tns_pkg::ctrl_cmd_t                cmd,
    output tns_pkg::dp_status_t               status,
    input  logic                              cfg_we,
    input  logic [tns_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tns_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              out_stall,
    output logic                              out_valid,
    output tns_pkg::out_event_t               out_data
);
    import tns_pkg::*;

    // configuration
    logic [POSITION_BITS-1:0] end_pos_reg, rpt_pos_reg;
    logic [7:0]               dpb_reg, bpb_reg;
    logic                     met_on_reg;
    logic [15:0]              mute_reg;
    logic [4:0]               solo_reg;

    // item and walk state
    in_item_t                 item_reg;
    logic                     bad_trk_reg;
    logic [TRK_W-1:0]         trk_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [POSITION_BITS-1:0] tgt_reg;
    logic [POSITION_BITS-1:0] cur_pos_reg;
    logic [CNT_W-1:0]         cnt_reg [NUM_TRACKS];
    logic [CNT_W-1:0]         nxt_reg [NUM_TRACKS];
    logic [7:0]               rem_reg [MELODY_TRACKS];
    logic [MELODY_TRACKS-1:0] snd_reg;
    logic                     skip_reg;

    // metronome divider
    logic [15:0]              prod_reg;
    logic [15:0]              div_rem_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     zero_db_reg, zero_d_reg;

    // store
    note_t                    mem [STORE_DEPTH];
    note_t                    rdata_reg;
    logic                     out_valid_reg;
    out_event_t               out_reg;

    logic [CNT_W-1:0]         cur_cnt, cur_nxt, idx_dec;
    logic [MEL_IDX_W-1:0]     mel_idx;
    logic                     is_melody, silenced, out_free, wrap;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [7:0]               d_eff, b_eff;
    logic [15:0]              divisor;
    logic [DIV_CNT_W-1:0]     div_bit_idx;
    logic [16:0]              div_shift, div_res;
    logic                     div_last;
    logic                     rd_en, wr_en;
    logic [ADDR_W-1:0]        rd_addr, wr_addr;
    note_t                    wr_data, new_note;
    out_event_t               ev;

    assign cur_cnt   = cnt_reg[trk_reg];
    assign cur_nxt   = nxt_reg[trk_reg];
    assign idx_dec   = idx_reg - 1'b1;
    assign mel_idx   = trk_reg[MEL_IDX_W-1:0];
    assign is_melody = (32'(trk_reg) < MELODY_TRACKS);
    assign silenced  = (32'(solo_reg) < NUM_TRACKS) && (32'(solo_reg) != 32'(trk_reg));
    assign out_free  = !out_valid_reg || !out_stall;
    assign pos_inc   = cur_pos_reg + 1'b1;
    assign wrap      = (pos_inc >= end_pos_reg);
    assign d_eff     = (dpb_reg == 8'd0) ? 8'd1 : dpb_reg;
    assign b_eff     = (bpb_reg == 8'd0) ? 8'd1 : bpb_reg;
    assign divisor   = (cmd.act == ACT_DIV_D) ? {8'd0, d_eff} : prod_reg;
    assign div_bit_idx = DIV_CNT_W'(POSITION_BITS - 1) - div_cnt_reg;
    assign div_shift = {div_rem_reg, cur_pos_reg[div_bit_idx]};
    assign div_res   = (div_shift >= {1'b0, divisor}) ? div_shift - {1'b0, divisor}
                                                      : div_shift;
    assign div_last  = (div_cnt_reg == DIV_CNT_W'(POSITION_BITS - 1));

    assign new_note.pos = item_reg.position;
    assign new_note.key = item_reg.note_key;
    assign new_note.len = item_reg.note_length;
    assign new_note.pan = item_reg.note_pan;
    assign new_note.vol = item_reg.note_volume;

    always_comb
    begin
        status.full     = bad_trk_reg || (cur_cnt == CNT_W'(NOTES_PER_TRACK));
        status.at_zero  = (idx_reg == '0);
        status.rd_gt    = (rdata_reg.pos > item_reg.position);
        status.sk_has   = (idx_reg < cur_cnt);
        status.rd_lt    = (rdata_reg.pos < tgt_reg);
        status.trk_last = (trk_reg == TRK_W'(NUM_TRACKS - 1));
        status.tk_has   = (cur_nxt < cur_cnt);
        status.rd_eq    = (rdata_reg.pos == cur_pos_reg);
        status.silenced = silenced;
        status.key_on   = (rdata_reg.key != NO_KEY) && !mute_reg[trk_reg];
        status.pan_set  = (rdata_reg.pan != NO_PAN);
        status.vol_set  = (rdata_reg.vol != NO_VOL);
        status.melody   = is_melody;
        status.skip     = skip_reg;
        status.rem_zero = (rem_reg[mel_idx] == 8'd0);
        status.sounding = snd_reg[mel_idx];
        status.met_on   = met_on_reg;
        status.div_last = div_last;
        status.zero_db  = zero_db_reg;
        status.zero_d   = zero_d_reg;
        status.wrap     = wrap;
        status.out_free = out_free;
    end

    // store port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {trk_reg, cur_nxt[IDX_W-1:0]};
        wr_en   = 1'b0;
        wr_addr = {trk_reg, idx_reg[IDX_W-1:0]};
        wr_data = new_note;
        case (cmd.act)
            ACT_LD_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = {trk_reg, idx_dec[IDX_W-1:0]};
            end
            ACT_SK_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = {trk_reg, idx_reg[IDX_W-1:0]};
            end
            ACT_TK_READ:
            begin
                rd_en = 1'b1;
            end
            ACT_LD_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_data = rdata_reg;
            end
            ACT_LD_WRITE:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // event fields by kind
    always_comb
    begin
        ev.event_kind    = cmd.kind;
        ev.event_track   = 4'd0;
        ev.event_key     = 8'd0;
        ev.event_value   = 8'd0;
        ev.play_position = cur_pos_reg;
        ev.last_event    = cmd.last;
        unique case (cmd.kind)
            EV_NOTE_ON:
            begin
                ev.event_track = 4'(trk_reg);
                ev.event_key   = rdata_reg.key;
            end
            EV_PAN:
            begin
                ev.event_track = 4'(trk_reg);
                ev.event_key   = rdata_reg.key;
                ev.event_value = rdata_reg.pan;
            end
            EV_VOLUME:
            begin
                ev.event_track = 4'(trk_reg);
                ev.event_key   = rdata_reg.key;
                ev.event_value = vol_scale(rdata_reg.vol);
            end
            EV_STOP:
            begin
                ev.event_track = 4'(trk_reg);
            end
            EV_LOADED, EV_FULL:
            begin
                ev.event_track = item_reg.track;
                ev.event_key   = item_reg.note_key;
            end
            default:
            begin
                ev.event_track = 4'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= ev;
        end
        if (cmd.act == ACT_CAPTURE)
        begin
            item_reg <= in_data;
        end
        if (cmd.act == ACT_MUL)
        begin
            prod_reg <= 16'(d_eff) * 16'(b_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_pos_reg   <= '0;
            rpt_pos_reg   <= '0;
            dpb_reg       <= 8'd4;
            bpb_reg       <= 8'd4;
            met_on_reg    <= 1'b0;
            mute_reg      <= '0;
            solo_reg      <= 5'(NUM_TRACKS);
            out_valid_reg <= 1'b0;
            bad_trk_reg   <= 1'b0;
            trk_reg       <= '0;
            idx_reg       <= '0;
            tgt_reg       <= '0;
            cur_pos_reg   <= '0;
            skip_reg      <= 1'b0;
            snd_reg       <= '0;
            div_rem_reg   <= '0;
            div_cnt_reg   <= '0;
            zero_db_reg   <= 1'b0;
            zero_d_reg    <= 1'b0;
            for (int i = 0; i < NUM_TRACKS; i++)
            begin
                cnt_reg[i] <= '0;
                nxt_reg[i] <= '0;
            end
            for (int i = 0; i < MELODY_TRACKS; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_END_POS: end_pos_reg <= cfg_data[POSITION_BITS-1:0];
                    CFG_RPT_POS: rpt_pos_reg <= cfg_data[POSITION_BITS-1:0];
                    CFG_DPB:     dpb_reg     <= cfg_data[7:0];
                    CFG_BPB:     bpb_reg     <= cfg_data[7:0];
                    CFG_MET_ON:  met_on_reg  <= cfg_data[0];
                    CFG_MUTE:    mute_reg    <= cfg_data[15:0];
                    CFG_SOLO:    solo_reg    <= cfg_data[4:0];
                    default:     met_on_reg  <= met_on_reg;
                endcase
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.act)
                ACT_CAPTURE:
                begin
                    trk_reg     <= (in_data.operation == OP_LOAD) ? TRK_W'(in_data.track)
                                                                  : '0;
                    bad_trk_reg <= (32'(in_data.track) >= NUM_TRACKS);
                    idx_reg     <= '0;
                    tgt_reg     <= in_data.position;
                    skip_reg    <= 1'b0;
                end
                ACT_LD_INIT:
                begin
                    idx_reg <= cur_cnt;
                end
                ACT_LD_SHIFT:
                begin
                    idx_reg <= idx_dec;
                end
                ACT_LD_WRITE:
                begin
                    cnt_reg[trk_reg] <= cur_cnt + 1'b1;
                    if (idx_reg < cur_nxt)
                    begin
                        nxt_reg[trk_reg] <= cur_nxt + 1'b1;
                    end
                end
                ACT_SK_STEP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                ACT_SK_SET:
                begin
                    nxt_reg[trk_reg] <= idx_reg;
                    trk_reg          <= trk_reg + 1'b1;
                    idx_reg          <= '0;
                end
                ACT_SK_FINISH:
                begin
                    cur_pos_reg <= tgt_reg;
                end
                ACT_TK_HIT:
                begin
                    nxt_reg[trk_reg] <= cur_nxt + 1'b1;
                    skip_reg         <= silenced;
                end
                ACT_TK_ON:
                begin
                    if (is_melody)
                    begin
                        rem_reg[mel_idx] <= rdata_reg.len;
                        snd_reg[mel_idx] <= 1'b1;
                    end
                end
                ACT_TK_DEC:
                begin
                    rem_reg[mel_idx] <= rem_reg[mel_idx] - 8'd1;
                end
                ACT_TK_STOP:
                begin
                    snd_reg[mel_idx] <= 1'b0;
                end
                ACT_TK_NEXT:
                begin
                    trk_reg  <= trk_reg + 1'b1;
                    skip_reg <= 1'b0;
                end
                ACT_MUL:
                begin
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                end
                ACT_DIV_DB, ACT_DIV_D:
                begin
                    if (div_last)
                    begin
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        if (cmd.act == ACT_DIV_DB)
                        begin
                            zero_db_reg <= (div_res == '0);
                        end
                        else
                        begin
                            zero_d_reg <= (div_res == '0);
                        end
                    end
                    else
                    begin
                        div_rem_reg <= div_res[15:0];
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                end
                ACT_ADVANCE:
                begin
                    if (wrap)
                    begin
                        tgt_reg <= rpt_pos_reg;
                        trk_reg <= '0;
                        idx_reg <= '0;
                    end
                    else
                    begin
                        cur_pos_reg <= pos_inc;
                    end
                end
                default:
                begin
                    skip_reg <= skip_reg;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a track never holds more notes than its store slice
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_cnt <= CNT_W'(NOTES_PER_TRACK))
        else $error("note count above store depth");

    // the play pointer never passes the end of its track
    a_nxt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_nxt <= cur_cnt)
        else $error("play pointer beyond note count");

    // a new event is only loaded when the output register is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("event overwrites a pending transaction");

    // a shift writes the entry that was read one slot lower
    a_shift_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.act == ACT_LD_SHIFT) |-> ($past(cmd.act) == ACT_LD_READ))
        else $error("store shift without preceding read");

endmodule

/* rtl/core/tracker_note_sequencer.sv */
// Top level of the tracker note sequencer: controller plus datapath.
// Depends on tns_pkg, tns_ctrl and tns_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one transaction per
//   command: load a note, tick, or seek. in_stall is high while a command is
//   being worked; one command is handled at a time.
//   Output channel (out_valid / out_stall / out_data) returns the events of a
//   command in order; last_event marks the final one. A held output waits in
//   its register and the engine pauses until the receiver takes it.
//   Configuration (cfg_we / cfg_index / cfg_data) writes one register per cycle
//   and should only be used while no command is in flight.
// Command steps (output stalls pause any of them):
//   load: find the insertion slot, moving later notes up one slot to make room, then write.
//   seek: per track, step past every note below the target and set the play pointer there.
//   tick: walk every track, then the bit-serial metronome remainder when enabled;
//   a position wrap then runs a full reseek to the repeat position.
// Reset clears every count, pointer, length and position; store contents stay
// undefined and are never read before being written, so no clearing pass runs.
module tracker_note_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tns_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tns_pkg::out_event_t               out_data,
    input  logic                              cfg_we,
    input  logic [tns_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tns_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tns_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing: walks tracks, store entries and events one step at a time
    tns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.operation),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // storage, pointers, divider and the output register
    tns_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
